>>> sv/dets_pkg.sv
`timescale 1ns / 1ps

package dets_pkg;

    localparam int MIN_W   = 8;
    localparam int SEC_W   = 6;
    localparam int CODE_W  = 15;
    localparam int STEP_W  = 3;

    localparam logic [SEC_W-1:0]  SEC_MAX     = SEC_W'(59);
    localparam logic [CODE_W-1:0] TIME_SCALE  = CODE_W'(100);
    localparam logic [1:0]        PINS_RESET  = 2'b11;

    // detent machine phases
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ALOW   = 2'd1,
        PH_DETENT = 2'd2,
        PH_BLOW   = 2'd3
    } dets_phase_t;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_LOAD   = 1'b1
    } dets_op_t;

    typedef struct packed {
        logic a;
        logic b;
    } dets_pins_t;

    // unit change reported by one encoder lane
    typedef struct packed {
        logic inc;
        logic dec;
    } dets_delta_t;

endpackage

>>> sv/dets_in_if.sv
`timescale 1ns / 1ps

interface dets_in_if
    import dets_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             operation;
    logic             enc1_a;
    logic             enc1_b;
    logic             enc2_a;
    logic             enc2_b;
    logic [MIN_W-1:0] load_minutes;
    logic [SEC_W-1:0] load_seconds;

    modport source (
        output valid, operation, enc1_a, enc1_b, enc2_a, enc2_b,
               load_minutes, load_seconds,
        input  ready
    );

    modport sink (
        input  valid, operation, enc1_a, enc1_b, enc2_a, enc2_b,
               load_minutes, load_seconds,
        output ready
    );
endinterface

>>> sv/dets_out_if.sv
`timescale 1ns / 1ps

interface dets_out_if
    import dets_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MIN_W-1:0]  set_minutes_out;
    logic [SEC_W-1:0]  set_seconds_out;
    logic [CODE_W-1:0] time_code;

    modport source (
        output valid, set_minutes_out, set_seconds_out, time_code,
        input  ready
    );

    modport sink (
        input  valid, set_minutes_out, set_seconds_out, time_code,
        output ready
    );
endinterface

>>> sv/dual_encoder_time_setter_top.sv
`timescale 1ns / 1ps
// Set-time adjuster driven by two quadrature encoders.
//
// sample: one item per encoder pin sample (operation = sample) or per
//   preload of the set time (operation = load). Encoder 1 steps the
//   seconds, encoder 2 steps the minutes; a full detent cycle ending
//   back in idle moves the value by one on the following sample.
// result: exactly one item per accepted sample item, carrying the set
//   minutes, seconds and minutes * 100 + seconds after that item.
//
// A result is valid the cycle after its item is taken. Both encoder
// lanes and the time merge update in the same cycle, so one item per
// cycle is sustained while result.ready is high.
// The single output register holds a result while result.ready is low;
// sample.ready is then low too, and the next item is taken in the cycle
// the held result leaves.
// Reset clears the set time to 00:00, puts both encoders in idle with a
// zero count and both pin histories high, and empties the output register.
module dual_encoder_time_setter_top
    import dets_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    dets_in_if.sink    sample,
    dets_out_if.source result
);

    logic              accept;
    logic              step_en;
    dets_op_t          op;
    dets_pins_t        pins1, pins2;
    dets_delta_t       delta1, delta2;
    logic [MIN_W-1:0]  min_next;
    logic [SEC_W-1:0]  sec_next;

    logic              out_valid_reg;
    logic [MIN_W-1:0]  out_min_reg;
    logic [SEC_W-1:0]  out_sec_reg;
    logic [CODE_W-1:0] out_code_reg;

    assign sample.ready = !out_valid_reg || result.ready;
    assign accept       = sample.valid && sample.ready;
    assign op           = dets_op_t'(sample.operation);
    assign step_en      = accept && (op == OP_SAMPLE);

    assign pins1.a = sample.enc1_a;
    assign pins1.b = sample.enc1_b;
    assign pins2.a = sample.enc2_a;
    assign pins2.b = sample.enc2_b;

    dets_enc_lane u_lane_sec (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .pins    (pins1),
        .delta   (delta1)
    );

    dets_enc_lane u_lane_min (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .pins    (pins2),
        .delta   (delta2)
    );

    dets_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .operation    (op),
        .sec_delta    (delta1),
        .min_delta    (delta2),
        .load_minutes (sample.load_minutes),
        .load_seconds (sample.load_seconds),
        .min_next     (min_next),
        .sec_next     (sec_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (sample.ready)
            out_valid_reg <= sample.valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_min_reg  <= min_next;
            out_sec_reg  <= sec_next;
            out_code_reg <= CODE_W'(min_next) * TIME_SCALE + CODE_W'(sec_next);
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.set_minutes_out = out_min_reg;
    assign result.set_seconds_out = out_sec_reg;
    assign result.time_code       = out_code_reg;

`ifndef SYNTHESIS
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result.valid)
        else $error("accepted item produced no result");

    a_seconds_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.set_seconds_out <= SEC_MAX))
        else $error("seconds out of range");

    a_code_match: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.time_code ==
            CODE_W'(result.set_minutes_out) * TIME_SCALE
            + CODE_W'(result.set_seconds_out)))
        else $error("time code does not match minutes and seconds");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> (result.valid && !result.ready))
        else $error("input stalled without a held result");
`endif

endmodule

>>> sv/dets_enc_lane.sv
`timescale 1ns / 1ps

module dets_enc_lane
    import dets_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step_en,
    input  dets_pins_t  pins,
    output dets_delta_t delta
);

    dets_phase_t              phase_reg, phase_next;
    logic signed [STEP_W-1:0] steps_reg, steps_next;
    logic [1:0]               prev_reg, prev_next;

    logic signed [STEP_W:0]   steps_w;
    logic                     oa, ob;

    localparam logic signed [STEP_W:0] STEPS_HI = (STEP_W+1)'(3);
    localparam logic signed [STEP_W:0] STEPS_LO = -(STEP_W+1)'(4);
    localparam logic signed [STEP_W-1:0] STEPS_FULL = STEP_W'(3);

    assign oa = prev_reg[0];
    assign ob = prev_reg[1];
    assign prev_next = {pins.b, pins.a};

    // count check happens in idle before the new pins are looked at
    always_comb
    begin
        delta.inc = 1'b0;
        delta.dec = 1'b0;
        if (phase_reg == PH_IDLE)
        begin
            delta.inc = (steps_reg == STEPS_FULL);
            delta.dec = (steps_reg == -STEPS_FULL);
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        steps_w    = (STEP_W+1)'(steps_reg);
        case (phase_reg)
            PH_IDLE:
            begin
                steps_w = '0;
                if ({pins.b, pins.a} != prev_reg)
                begin
                    if (!pins.a && pins.b)
                    begin
                        if (oa)
                        begin
                            phase_next = PH_ALOW;
                            steps_w    = (STEP_W+1)'(1);
                        end
                    end
                    else if (pins.a && !pins.b)
                    begin
                        if (ob)
                        begin
                            phase_next = PH_BLOW;
                            steps_w    = -(STEP_W+1)'(1);
                        end
                    end
                end
            end
            PH_ALOW:
            begin
                if (!pins.a && !pins.b)
                begin
                    if (ob)
                    begin
                        phase_next = PH_DETENT;
                        steps_w    = steps_w + (STEP_W+1)'(1);
                    end
                end
                else if (pins.a && pins.b)
                begin
                    if (!oa)
                        phase_next = PH_IDLE;
                end
            end
            PH_DETENT:
            begin
                if (pins.a && !pins.b)
                begin
                    if (!oa)
                    begin
                        phase_next = PH_BLOW;
                        steps_w    = steps_w + (STEP_W+1)'(1);
                    end
                end
                else if (!pins.a && pins.b)
                begin
                    if (!ob)
                    begin
                        phase_next = PH_ALOW;
                        steps_w    = steps_w - (STEP_W+1)'(1);
                    end
                end
            end
            PH_BLOW:
            begin
                if (pins.a && pins.b)
                begin
                    if (!ob)
                        phase_next = PH_IDLE;
                end
                else if (!pins.a && !pins.b)
                begin
                    if (oa)
                    begin
                        phase_next = PH_DETENT;
                        steps_w    = steps_w - (STEP_W+1)'(1);
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        if (steps_w > STEPS_HI)
            steps_next = STEP_W'(STEPS_HI);
        else if (steps_w < STEPS_LO)
            steps_next = STEP_W'(STEPS_LO);
        else
            steps_next = steps_w[STEP_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            steps_reg <= '0;
            prev_reg  <= PINS_RESET;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            steps_reg <= steps_next;
            prev_reg  <= prev_next;
        end
    end

endmodule

>>> sv/dets_merge.sv
`timescale 1ns / 1ps

module dets_merge
    import dets_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  dets_op_t         operation,
    input  dets_delta_t      sec_delta,
    input  dets_delta_t      min_delta,
    input  logic [MIN_W-1:0] load_minutes,
    input  logic [SEC_W-1:0] load_seconds,
    output logic [MIN_W-1:0] min_next,
    output logic [SEC_W-1:0] sec_next
);

    logic [MIN_W-1:0] min_reg;
    logic [SEC_W-1:0] sec_reg;
    logic             carry;

    always_comb
    begin
        carry    = 1'b0;
        sec_next = sec_reg;
        min_next = min_reg;
        case (operation)
            OP_LOAD:
            begin
                min_next = load_minutes;
                sec_next = (load_seconds > SEC_MAX) ? SEC_MAX : load_seconds;
            end
            OP_SAMPLE:
            begin
                if (sec_delta.inc)
                begin
                    if (sec_reg == SEC_MAX)
                    begin
                        sec_next = '0;
                        carry    = 1'b1;
                    end
                    else
                        sec_next = sec_reg + SEC_W'(1);
                end
                else if (sec_delta.dec)
                begin
                    // no borrow into minutes on the way down
                    sec_next = (sec_reg == '0) ? SEC_MAX : sec_reg - SEC_W'(1);
                end

                if (min_delta.inc)
                    min_next = min_reg + MIN_W'(1) + MIN_W'(carry);
                else if (min_delta.dec)
                    min_next = min_reg - MIN_W'(1) + MIN_W'(carry);
                else
                    min_next = min_reg + MIN_W'(carry);
            end
            default:
            begin
                sec_next = sec_reg;
                min_next = min_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= '0;
            sec_reg <= '0;
        end
        else if (accept)
        begin
            min_reg <= min_next;
            sec_reg <= sec_next;
        end
    end

endmodule
